// ===== design/mead_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mead_pkg
// Shared constants and types for the motor encoder angle and drive block.
// ----------------------------------------------------------------------------
package mead_pkg;

    // width of the wrapping encoder count (16..64)
    localparam int COUNT_BITS = 32;

    // shift register of the shared divider: holds the count magnitude or the
    // low bits of the scaled remainder, whichever is wider
    localparam int QUO_BITS   = 17;
    localparam int SH_W       = (COUNT_BITS > QUO_BITS) ? COUNT_BITS : QUO_BITS;
    localparam int CNT_W      = $clog2(SH_W + 1);

    localparam int TICK_W     = 16;
    localparam int PROD_W     = TICK_W + QUO_BITS;

    // angle scale, 1/256 degree
    localparam logic [QUO_BITS-1:0] FULL_TURN_Q8 = 17'd92160;
    localparam logic signed [17:0]  HALF_POS     = 18'sd46080;
    localparam logic signed [17:0]  HALF_NEG     = -18'sd46080;
    localparam logic signed [17:0]  FULL_TURN_S  = 18'sd92160;

    localparam logic [TICK_W-1:0]   TICKS_RESET  = 16'd1024;

    localparam logic signed [15:0]  SPEED_MAX    = 16'sd255;
    localparam logic signed [15:0]  SPEED_MIN    = -16'sd255;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_DRIVE = 2'd1,
        OP_ZERO  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // H-bridge pin codes, bit 0 in1, bit 1 in2
    localparam logic [1:0] PINS_OFF   = 2'b00;
    localparam logic [1:0] PINS_FWD   = 2'b01;
    localparam logic [1:0] PINS_REV   = 2'b10;
    localparam logic [1:0] PINS_BRAKE = 2'b11;

endpackage
`default_nettype wire

// ===== design/motor_encoder_angle_and_drive.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motor_encoder_angle_and_drive
// Quadrature edge counter, H-bridge direction/duty register and angle readout.
//
// Input channel (s_*): one item per event. tuser carries the op (edge, drive,
// set zero, read). Each accepted item yields exactly one result on the m_*
// channel: the count, the angle in 1/256 degree, both bridge pins and the duty.
// The state update happens in the accept cycle; the angle is then worked out
// by one restoring subtract/compare unit: COUNT_BITS steps for the remainder
// modulo ticks_per_rev, one multiply by 92160, 17 steps for the quotient.
// The block takes one item at a time; o_s_tready is low while one is in work.
// The result sits in an output register; a new item may be accepted while it
// waits. If the receiver still stalls when the next result is done, the
// sequencer holds it until the register frees up.
// ticks_per_rev is written on the cfg channel, which is ready only while idle.
// Reset: count, zero reference and duty clear, both pins low, 1024 ticks.
// ----------------------------------------------------------------------------
module motor_encoder_angle_and_drive
    import mead_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [23:0]          i_s_tdata,  // chan_a_level, chan_b_level,
                                                  // speed_request[15:0], zero pad
    input  wire logic [1:0]           i_s_tuser,  // op
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [63:0]               o_m_tdata,  // tick_count[31:0], angle_q8[16:0],
                                                  // in1_level, in2_level,
                                                  // pwm_duty[7:0], zero pad
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [TICK_W-1:0]    i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MOD  = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic [COUNT_BITS-1:0]   r_zero, n_zero;
    logic [1:0]              r_pins, n_pins;
    logic [7:0]              r_duty, n_duty;
    logic [TICK_W-1:0]       r_ticks;
    logic [TICK_W-1:0]       r_rem, n_rem;
    logic [SH_W-1:0]         r_sh, n_sh;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_neg, n_neg;
    logic                    r_out_valid, n_out_valid;
    logic [63:0]             r_out, n_out;

    t_op                     op;
    logic signed [15:0]      speed;
    logic signed [15:0]      speed_neg;
    logic                    in_acc;

    logic [COUNT_BITS-1:0]   diff;
    logic [COUNT_BITS-1:0]   mag;

    logic [TICK_W:0]         trial;
    logic                    ge;
    logic [TICK_W:0]         trial_sub;
    logic [PROD_W-1:0]       prod;

    logic signed [17:0]      s_raw;
    logic signed [17:0]      s_fix;
    logic signed [63:0]      cnt_ext;
    logic                    out_free;

    assign op          = t_op'(i_s_tuser);
    assign speed       = $signed(i_s_tdata[17:2]);
    assign speed_neg   = -speed;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;

    assign diff = r_count - r_zero;
    assign mag  = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;

    // shared restoring divide step
    assign trial     = {r_rem, r_sh[SH_W-1]};
    assign ge        = (trial >= {1'b0, r_ticks});
    assign trial_sub = trial - {1'b0, r_ticks};
    assign prod      = PROD_W'(r_rem) * PROD_W'(FULL_TURN_Q8);

    assign s_raw   = r_neg ? -$signed({1'b0, r_sh[QUO_BITS-1:0]})
                           : $signed({1'b0, r_sh[QUO_BITS-1:0]});
    assign cnt_ext = 64'(signed'(r_count));
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        if (r_ticks == '0) begin
            s_fix = '0;
        end else if (s_raw > HALF_POS) begin
            s_fix = s_raw - FULL_TURN_S;
        end else if (s_raw <= HALF_NEG) begin
            s_fix = s_raw + FULL_TURN_S;
        end else begin
            s_fix = s_raw;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_zero      = r_zero;
        n_pins      = r_pins;
        n_duty      = r_duty;
        n_rem       = r_rem;
        n_sh        = r_sh;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (op)
                        OP_EDGE: begin
                            // up only on A high, B low
                            if (i_s_tdata[0] && !i_s_tdata[1]) begin
                                n_count = r_count + 1'b1;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_DRIVE: begin
                            if (speed > SPEED_MAX) begin
                                n_pins = PINS_FWD;
                                n_duty = 8'hFF;
                            end else if (speed < SPEED_MIN) begin
                                n_pins = PINS_REV;
                                n_duty = 8'hFF;
                            end else if (speed == '0) begin
                                n_pins = PINS_BRAKE;
                            end else if (speed > 0) begin
                                n_pins = PINS_FWD;
                                n_duty = speed[7:0];
                            end else begin
                                n_pins = PINS_REV;
                                n_duty = speed_neg[7:0];
                            end
                        end
                        OP_ZERO: begin
                            n_zero = r_count;
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_neg   = diff[COUNT_BITS-1];
                n_rem   = '0;
                n_sh    = SH_W'(mag) << (SH_W - COUNT_BITS);
                n_cnt   = CNT_W'(COUNT_BITS - 1);
                n_state = S_MOD;
            end
            S_MOD: begin
                n_rem = ge ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
                n_sh  = {r_sh[SH_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // quotient < 2^17, so the top bits already sit below ticks
                n_rem   = prod[PROD_W-1:QUO_BITS];
                n_sh    = SH_W'(prod[QUO_BITS-1:0]) << (SH_W - QUO_BITS);
                n_cnt   = CNT_W'(QUO_BITS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
                n_sh  = {r_sh[SH_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = {5'd0, r_duty, r_pins[1], r_pins[0],
                                   s_fix[16:0], cnt_ext[31:0]};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_zero      <= '0;
            r_pins      <= PINS_OFF;
            r_duty      <= '0;
            r_ticks     <= TICKS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_zero      <= n_zero;
            r_pins      <= n_pins;
            r_duty      <= n_duty;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_out <= n_out;
    end

endmodule
`default_nettype wire
